/* hdl/two_bone_planar_ik_defines.svh */
// assertion macros for the two-bone planar ik block
// used by the top level only; expects i_clk and i_rst_n in scope
`ifndef TWO_BONE_PLANAR_IK_DEFINES_SVH
`define TWO_BONE_PLANAR_IK_DEFINES_SVH

// same-cycle implication, off during reset
`define TBPIK_ASSERT_IMPLY(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("tbpik implication check failed");

// next-cycle implication, off during reset
`define TBPIK_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("tbpik next-cycle check failed");

`endif

/* hdl/tbpik_pkg.sv */
// shared types, constants and the cordic arctangent table
// no dependencies
`default_nettype none

package tbpik_pkg;

    localparam int FRAC_BITS = 12;
    localparam int ANG_SH    = 30 - FRAC_BITS;

    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [34:0] GAIN_INV_Q30 = 35'sd652032874;
    localparam logic [30:0]        ONE_Q30     = 31'h4000_0000;

    localparam logic [2:0] CFG_ROOT_X       = 3'd0;
    localparam logic [2:0] CFG_ROOT_Y       = 3'd1;
    localparam logic [2:0] CFG_UPPER_LENGTH = 3'd2;
    localparam logic [2:0] CFG_LOWER_LENGTH = 3'd3;
    localparam logic [2:0] CFG_BEND_MODE    = 3'd4;

    typedef struct packed {
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic               sh_ok;
        logic               el_ok;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic busy;
        logic pop;
    } t_bk_stat;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            5'd24: v = 30'h0000003F;
            5'd25: v = 30'h0000001F;
            5'd26: v = 30'h0000000F;
            5'd27: v = 30'h00000007;
            5'd28: v = 30'h00000003;
            5'd29: v = 30'h00000001;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hdl/tbpik_if.sv */
// request channels of the ik block: target in, solved pose out
// no dependencies
`default_nettype none

interface tbpik_tgt_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    modport source (output valid, target_x, target_y, input ready);
    modport sink   (input valid, target_x, target_y, output ready);
endinterface

interface tbpik_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] shoulder_angle;
    logic signed [15:0] elbow_angle;
    logic signed [23:0] elbow_x;
    logic signed [23:0] elbow_y;
    logic signed [23:0] tip_x;
    logic signed [23:0] tip_y;
    modport source (output valid, shoulder_angle, elbow_angle, elbow_x, elbow_y,
                    tip_x, tip_y, input ready);
    modport sink   (input valid, shoulder_angle, elbow_angle, elbow_x, elbow_y,
                    tip_x, tip_y, output ready);
endinterface

`default_nettype wire

/* hdl/two_bone_planar_ik.sv */
// two-bone planar ik, top level: configuration registers, front, queue, back
// depends on tbpik_pkg, tbpik_if, tbpik_front, tbpik_fifo, tbpik_back and the defines header
`default_nettype none
`include "two_bone_planar_ik_defines.svh"

// Each target request (signed Q12 x, y) yields one pose: the shoulder angle
// (atan2 to the target minus the law-of-cosines interior angle for an arm,
// plus it for a leg), the elbow angle (-(pi+acos) arm, pi+acos leg), both in
// signed Q12 radians, and the elbow and tip positions in signed Q12, saturated
// to 24 bits. A target on the root, or a zero upper length, keeps the last
// shoulder angle; a zero bone length keeps the last elbow angle; both reset
// to zero. The front takes a request, forms the offset to the root and the
// degenerate-case flags and hands it to a two-entry queue, so up to three
// requests can wait while the back works. The back solves one request at a
// time with a shared 32x32 multiplier, a one-digit-per-cycle square root (run
// for the target distance when the shoulder is solved, and once per angle
// solved), a restoring divider and a shared cordic unit (30 micro-rotations
// plus normalization, five passes at most). Configuration writes
// (index 0 root_x, 1 root_y, 2 upper_length, 3 lower_length, 4 bend_mode)
// must only be made while the block is idle.
module two_bone_planar_ik (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data,
    tbpik_tgt_if.sink        i_tgt,
    tbpik_res_if.source      o_res
);
    import tbpik_pkg::*;

    // configuration registers
    logic signed [23:0] r_root_x;
    logic signed [23:0] r_root_y;
    logic [22:0]        r_upper_length;
    logic [22:0]        r_lower_length;
    logic               r_bend_mode;

    // front to queue to back
    t_job     fr_job;
    logic     fr_push;
    t_job     q_head;
    t_q_stat  q_stat;
    t_bk_stat bk_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_x       <= '0;
            r_root_y       <= '0;
            r_upper_length <= 23'd40960;
            r_lower_length <= 23'd40960;
            r_bend_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROOT_X:       r_root_x       <= i_cfg_data;
                CFG_ROOT_Y:       r_root_y       <= i_cfg_data;
                CFG_UPPER_LENGTH: r_upper_length <= i_cfg_data[22:0];
                CFG_LOWER_LENGTH: r_lower_length <= i_cfg_data[22:0];
                CFG_BEND_MODE:    r_bend_mode    <= i_cfg_data[0];
                default:          ;  // unmapped index, write dropped
            endcase
        end
    end

    // request intake and classification
    tbpik_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tgt          (i_tgt),
        .i_root_x       (r_root_x),
        .i_root_y       (r_root_y),
        .i_upper_length (r_upper_length),
        .i_lower_length (r_lower_length),
        .i_q_full       (q_stat.full),
        .o_job          (fr_job),
        .o_push         (fr_push)
    );

    // decouples intake from the solver
    tbpik_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_job   (fr_job),
        .i_pop   (bk_stat.pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // solver and output register
    tbpik_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .i_q            (q_stat),
        .i_root_x       (r_root_x),
        .i_root_y       (r_root_y),
        .i_upper_length (r_upper_length),
        .i_lower_length (r_lower_length),
        .i_bend_mode    (r_bend_mode),
        .o_res          (o_res),
        .o_stat         (bk_stat)
    );

    // queue never written when full nor read when empty
    `TBPIK_ASSERT_IMPLY(a_no_overflow, fr_push, !q_stat.full)
    `TBPIK_ASSERT_IMPLY(a_no_underflow, bk_stat.pop, !q_stat.empty)
    // a popped job keeps the solver busy
    `TBPIK_ASSERT_NEXT(a_pop_busy, bk_stat.pop, bk_stat.busy)
    // a new pose only appears at the end of a solve
    `TBPIK_ASSERT_IMPLY(a_res_from_solve, $rose(o_res.valid), $past(bk_stat.busy))

endmodule

`default_nettype wire

/* hdl/tbpik_front.sv */
// front end: takes target requests, forms the offset to the root and the
// degenerate-case flags; depends on tbpik_pkg and tbpik_if
`default_nettype none

module tbpik_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    tbpik_tgt_if.sink               i_tgt,
    input  wire logic signed [23:0] i_root_x,
    input  wire logic signed [23:0] i_root_y,
    input  wire logic [22:0]        i_upper_length,
    input  wire logic [22:0]        i_lower_length,
    input  wire logic               i_q_full,
    output tbpik_pkg::t_job         o_job,
    output logic                    o_push
);
    import tbpik_pkg::*;

    logic  r_vld;
    t_job  r_job;
    t_job  n_job;

    assign i_tgt.ready = !r_vld || !i_q_full;
    assign o_push      = r_vld && !i_q_full;
    assign o_job       = r_job;

    always_comb begin
        n_job.dx    = $signed({i_tgt.target_x[23], i_tgt.target_x})
                    - $signed({i_root_x[23], i_root_x});
        n_job.dy    = $signed({i_tgt.target_y[23], i_tgt.target_y})
                    - $signed({i_root_y[23], i_root_y});
        // target on the root leaves the shoulder as it was
        n_job.sh_ok = (i_upper_length != '0) && ((n_job.dx != '0) || (n_job.dy != '0));
        n_job.el_ok = (i_upper_length != '0) && (i_lower_length != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_tgt.valid && i_tgt.ready) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tgt.valid && i_tgt.ready) begin
            r_job <= n_job;
        end
    end

endmodule

`default_nettype wire

/* hdl/tbpik_fifo.sv */
// two-entry queue of classified jobs between front and back
// depends on tbpik_pkg
`default_nettype none

module tbpik_fifo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  tbpik_pkg::t_job   i_job,
    input  wire logic         i_pop,
    output tbpik_pkg::t_job   o_head,
    output tbpik_pkg::t_q_stat o_stat
);
    import tbpik_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

/* hdl/tbpik_cordic.sv */
// shared cordic unit, one micro-rotation per cycle: vectoring gives atan2,
// rotation gives cos and sin; depends on tbpik_pkg
`default_nettype none

module tbpik_cordic (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_rotate,
    input  wire logic signed [34:0] i_x,
    input  wire logic signed [34:0] i_y,
    input  wire logic signed [35:0] i_ang,
    output logic                    o_done,
    output logic signed [34:0]      o_x,
    output logic signed [34:0]      o_y,
    output logic signed [35:0]      o_z
);
    import tbpik_pkg::*;

    typedef enum logic [2:0] {C_IDLE, C_PRE, C_NORM, C_MOD, C_ITER, C_FIN} t_cst;

    t_cst               r_st;
    logic               r_rot;
    logic               r_neg;
    logic               r_done;
    logic [4:0]         r_i;
    logic signed [34:0] r_x;
    logic signed [34:0] r_y;
    logic signed [35:0] r_z;

    logic signed [34:0] xs;
    logic signed [34:0] ys;
    logic signed [35:0] tab;
    logic signed [35:0] f1;
    logic signed [35:0] f2;
    logic               fneg;
    logic               near_zero;

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

    always_comb begin
        xs        = r_x >>> r_i;
        ys        = r_y >>> r_i;
        tab       = $signed({6'b0, atan_q30(r_i)});
        near_zero = (r_x < 35'sd536870912) && (r_x > -35'sd536870912)
                 && (r_y < 35'sd536870912) && (r_y > -35'sd536870912);
        // fold the reduced angle into [-pi/2, pi/2]
        if (r_z > PI_Q30) begin
            f1 = r_z - TWO_PI_Q30;
        end else if (r_z < -PI_Q30) begin
            f1 = r_z + TWO_PI_Q30;
        end else begin
            f1 = r_z;
        end
        fneg = 1'b0;
        if (f1 > HALF_PI_Q30) begin
            f2   = f1 - PI_Q30;
            fneg = 1'b1;
        end else if (f1 < -HALF_PI_Q30) begin
            f2   = f1 + PI_Q30;
            fneg = 1'b1;
        end else begin
            f2 = f1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= C_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_st == C_FIN);
            unique case (r_st)
                C_IDLE: begin
                    if (i_start) begin
                        r_rot <= i_rotate;
                        r_neg <= 1'b0;
                        r_x   <= i_x;
                        r_y   <= i_y;
                        r_z   <= i_rotate ? i_ang : '0;
                        r_st  <= i_rotate ? C_MOD : C_PRE;
                    end
                end
                C_PRE: begin
                    if (r_x == '0 && r_y == '0) begin
                        r_st <= C_FIN;
                    end else begin
                        if (r_x < 0) begin
                            r_z <= (r_y >= 0) ? PI_Q30 : -PI_Q30;
                            r_x <= -r_x;
                            r_y <= -r_y;
                        end
                        r_st <= C_NORM;
                    end
                end
                C_NORM: begin
                    if (near_zero) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        r_i  <= '0;
                        r_st <= C_ITER;
                    end
                end
                C_MOD: begin
                    // remainder by two pi, sign of the dividend
                    if (r_z >= TWO_PI_Q30) begin
                        r_z <= r_z - TWO_PI_Q30;
                    end else if (r_z <= -TWO_PI_Q30) begin
                        r_z <= r_z + TWO_PI_Q30;
                    end else begin
                        r_z   <= f2;
                        r_neg <= fneg;
                        r_x   <= GAIN_INV_Q30;
                        r_y   <= '0;
                        r_i   <= '0;
                        r_st  <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (r_rot) begin
                        if (r_z >= 0) begin
                            r_x <= r_x - ys;
                            r_y <= r_y + xs;
                            r_z <= r_z - tab;
                        end else begin
                            r_x <= r_x + ys;
                            r_y <= r_y - xs;
                            r_z <= r_z + tab;
                        end
                    end else begin
                        if (r_y >= 0) begin
                            r_x <= r_x + ys;
                            r_y <= r_y - xs;
                            r_z <= r_z + tab;
                        end else begin
                            r_x <= r_x - ys;
                            r_y <= r_y + xs;
                            r_z <= r_z - tab;
                        end
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'd29) begin
                        r_st <= C_FIN;
                    end
                end
                C_FIN: begin
                    if (r_rot && r_neg) begin
                        r_x <= -r_x;
                        r_y <= -r_y;
                    end
                    r_st <= C_IDLE;
                end
                default: r_st <= C_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/tbpik_back.sv */
// back end: sequencer over a shared multiplier, square root, divider and
// cordic unit; keeps the last angles; depends on tbpik_pkg, tbpik_if, tbpik_cordic
`default_nettype none

module tbpik_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  tbpik_pkg::t_job         i_head,
    input  tbpik_pkg::t_q_stat      i_q,
    input  wire logic signed [23:0] i_root_x,
    input  wire logic signed [23:0] i_root_y,
    input  wire logic [22:0]        i_upper_length,
    input  wire logic [22:0]        i_lower_length,
    input  wire logic               i_bend_mode,
    tbpik_res_if.source             o_res,
    output tbpik_pkg::t_bk_stat     o_stat
);
    import tbpik_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_D2A, S_D2B, S_LLA, S_LLB, S_LLC, S_SQD, S_MD, S_DVL, S_DIV,
        S_DVE, S_CC, S_SQL, S_SQA, S_ACS, S_ACW, S_ATS, S_ATW, S_ELQ,
        S_RS0, S_RW0, S_OXA, S_OXB, S_OYB, S_RS1, S_RW1, S_OXC, S_OXD, S_OYD,
        S_DONE
    } t_st;

    t_st                r_st;
    t_job               r_job;
    logic               r_el;
    logic signed [63:0] r_prod;
    logic [49:0]        r_d2;
    logic [45:0]        r_ll0;
    logic [45:0]        r_ll1;
    logic [60:0]        r_sq_v;
    logic [61:0]        r_sq_r;
    logic [4:0]         r_sq_k;
    logic [24:0]        r_dist;
    logic [49:0]        r_den;
    logic [51:0]        r_dv_a;
    logic [30:0]        r_dv_q;
    logic               r_dv_neg;
    logic [4:0]         r_dv_n;
    logic signed [31:0] r_c;
    logic signed [35:0] r_acos;
    logic signed [15:0] r_sh_kept;
    logic signed [15:0] r_el_kept;
    logic signed [35:0] r_ex;
    logic signed [35:0] r_ey;
    logic signed [36:0] r_tx;
    logic signed [36:0] r_ty;
    logic               r_ov;
    logic signed [15:0] r_o_sh;
    logic signed [15:0] r_o_el;
    logic signed [23:0] r_o_ex;
    logic signed [23:0] r_o_ey;
    logic signed [23:0] r_o_tx;
    logic signed [23:0] r_o_ty;

    logic signed [31:0] ma;
    logic signed [31:0] mb;
    logic [61:0]        sq_bit;
    logic [62:0]        sq_sum;
    logic [60:0]        n_sq_v;
    logic [61:0]        n_sq_r;
    logic [51:0]        num;
    logic [51:0]        num_abs;
    logic [49:0]        den;
    logic [51:0]        dv_a2;
    logic signed [35:0] off;
    logic signed [35:0] ang0;
    logic signed [35:0] el_ext;
    logic               cd_start;
    logic               cd_rot;
    logic signed [34:0] cd_x;
    logic signed [34:0] cd_y;
    logic signed [35:0] cd_ang;
    logic               cd_done;
    logic signed [34:0] cd_ox;
    logic signed [34:0] cd_oy;
    logic signed [35:0] cd_oz;

    function automatic logic signed [15:0] ang_q(input logic signed [36:0] v);
        logic signed [36:0] t;
        t = (v + (37'sd1 <<< (ANG_SH - 1))) >>> ANG_SH;
        if (t > 37'sd32767) begin
            return 16'sh7FFF;
        end else if (t < -37'sd32768) begin
            return -16'sh8000;
        end
        return t[15:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [36:0] v);
        if (v > 37'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -37'sd8388608) begin
            return -24'sh800000;
        end
        return v[23:0];
    endfunction

    assign o_stat.busy = (r_st != S_IDLE);
    assign o_stat.pop  = (r_st == S_IDLE) && !i_q.empty;

    assign o_res.valid          = r_ov;
    assign o_res.shoulder_angle = r_o_sh;
    assign o_res.elbow_angle    = r_o_el;
    assign o_res.elbow_x        = r_o_ex;
    assign o_res.elbow_y        = r_o_ey;
    assign o_res.tip_x          = r_o_tx;
    assign o_res.tip_y          = r_o_ty;

    // operand select for the shared multiplier
    always_comb begin
        ma = '0;
        mb = '0;
        unique case (r_st)
            S_D2A:       begin ma = 32'(r_job.dx); mb = 32'(r_job.dx); end
            S_D2B:       begin ma = 32'(r_job.dy); mb = 32'(r_job.dy); end
            S_LLA:       begin ma = $signed({9'b0, i_upper_length});
                               mb = $signed({9'b0, i_upper_length}); end
            S_LLB:       begin ma = $signed({9'b0, i_lower_length});
                               mb = $signed({9'b0, i_lower_length}); end
            S_MD:        begin ma = $signed({9'b0, i_upper_length});
                               mb = r_el ? $signed({9'b0, i_lower_length})
                                         : $signed({7'b0, r_dist}); end
            S_CC:        begin ma = r_c; mb = r_c; end
            S_OXA:       begin ma = $signed({9'b0, i_upper_length}); mb = cd_ox[31:0]; end
            S_OXB:       begin ma = $signed({9'b0, i_upper_length}); mb = cd_oy[31:0]; end
            S_OXC:       begin ma = $signed({9'b0, i_lower_length}); mb = cd_ox[31:0]; end
            S_OXD:       begin ma = $signed({9'b0, i_lower_length}); mb = cd_oy[31:0]; end
            default:     begin ma = '0; mb = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
    end

    always_comb begin
        // square root digit step
        sq_bit = 62'(1) << {r_sq_k, 1'b0};
        sq_sum = 63'(r_sq_r) + 63'(sq_bit);
        if (63'(r_sq_v) >= sq_sum) begin
            n_sq_v = r_sq_v - sq_sum[60:0];
            n_sq_r = (r_sq_r >> 1) + sq_bit;
        end else begin
            n_sq_v = r_sq_v;
            n_sq_r = r_sq_r >> 1;
        end
        // law of cosines numerator and denominator
        num     = r_el ? (52'(r_ll0) + 52'(r_ll1) - 52'(r_d2))
                       : (52'(r_ll0) - 52'(r_ll1) + 52'(r_d2));
        num_abs = num[51] ? -num : num;
        den     = {r_prod[48:0], 1'b0};
        dv_a2   = {r_dv_a[50:0], 1'b0};
        off     = 36'((r_prod + 64'sd536870912) >>> 30);
        ang0    = 36'(r_sh_kept) <<< ANG_SH;
        el_ext  = 36'(r_el_kept) <<< ANG_SH;
        // cordic request
        cd_start = (r_st == S_ACS) || (r_st == S_ATS) || (r_st == S_RS0) || (r_st == S_RS1);
        cd_rot   = (r_st == S_RS0) || (r_st == S_RS1);
        cd_x     = (r_st == S_ACS) ? 35'(r_c) : 35'(r_job.dx);
        cd_y     = (r_st == S_ACS) ? $signed({1'b0, r_sq_r[33:0]}) : 35'(r_job.dy);
        cd_ang   = (r_st == S_RS1) ? (ang0 + el_ext) : ang0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_ov      <= 1'b0;
            r_sh_kept <= '0;
            r_el_kept <= '0;
        end else begin
            if (r_st == S_DONE && (!r_ov || o_res.ready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_res.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (!i_q.empty) begin
                        r_job <= i_head;
                        r_st  <= S_D2A;
                    end
                end
                S_D2A: r_st <= S_D2B;
                S_D2B: begin
                    r_d2 <= r_prod[49:0];
                    r_st <= S_LLA;
                end
                S_LLA: begin
                    r_d2 <= r_d2 + r_prod[49:0];
                    r_st <= S_LLB;
                end
                S_LLB: begin
                    r_ll0 <= r_prod[45:0];
                    r_st  <= S_LLC;
                end
                S_LLC: begin
                    r_ll1  <= r_prod[45:0];
                    r_sq_v <= 61'(r_d2);
                    r_sq_r <= '0;
                    r_sq_k <= 5'd30;
                    priority if (r_job.sh_ok) begin
                        r_el <= 1'b0;
                        r_st <= S_SQD;
                    end else if (r_job.el_ok) begin
                        r_el <= 1'b1;
                        r_st <= S_MD;
                    end else begin
                        r_st <= S_RS0;
                    end
                end
                S_SQD: begin
                    r_sq_v <= n_sq_v;
                    r_sq_r <= n_sq_r;
                    r_sq_k <= r_sq_k - 5'd1;
                    if (r_sq_k == '0) begin
                        r_dist <= n_sq_r[24:0];
                        r_st   <= S_MD;
                    end
                end
                S_MD: r_st <= S_DVL;
                S_DVL: begin
                    r_den    <= den;
                    r_dv_a   <= num_abs;
                    r_dv_neg <= num[51];
                    r_dv_q   <= (num_abs >= 52'(den)) ? ONE_Q30 : '0;
                    r_dv_n   <= '0;
                    if (num_abs >= 52'(den)) begin
                        r_st <= S_DVE;
                    end else begin
                        r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (dv_a2 >= 52'(r_den)) begin
                        r_dv_a <= dv_a2 - 52'(r_den);
                        r_dv_q <= {r_dv_q[29:0], 1'b1};
                    end else begin
                        r_dv_a <= dv_a2;
                        r_dv_q <= {r_dv_q[29:0], 1'b0};
                    end
                    r_dv_n <= r_dv_n + 5'd1;
                    if (r_dv_n == 5'd29) begin
                        r_st <= S_DVE;
                    end
                end
                S_DVE: begin
                    r_c  <= r_dv_neg ? -$signed({1'b0, r_dv_q}) : $signed({1'b0, r_dv_q});
                    r_st <= S_CC;
                end
                S_CC: r_st <= S_SQL;
                S_SQL: begin
                    // sine of the interior angle from one minus cosine squared
                    r_sq_v <= (61'(1) << 60) - r_prod[60:0];
                    r_sq_r <= '0;
                    r_sq_k <= 5'd30;
                    r_st   <= S_SQA;
                end
                S_SQA: begin
                    r_sq_v <= n_sq_v;
                    r_sq_r <= n_sq_r;
                    r_sq_k <= r_sq_k - 5'd1;
                    if (r_sq_k == '0) begin
                        r_st <= S_ACS;
                    end
                end
                S_ACS: r_st <= S_ACW;
                S_ACW: begin
                    if (cd_done) begin
                        r_acos <= cd_oz;
                        r_st   <= r_el ? S_ELQ : S_ATS;
                    end
                end
                S_ATS: r_st <= S_ATW;
                S_ATW: begin
                    if (cd_done) begin
                        r_sh_kept <= ang_q(i_bend_mode ? (37'(cd_oz) + 37'(r_acos))
                                                       : (37'(cd_oz) - 37'(r_acos)));
                        if (r_job.el_ok) begin
                            r_el <= 1'b1;
                            r_st <= S_MD;
                        end else begin
                            r_st <= S_RS0;
                        end
                    end
                end
                S_ELQ: begin
                    r_el_kept <= ang_q(i_bend_mode ? (37'(PI_Q30) + 37'(r_acos))
                                                   : -(37'(PI_Q30) + 37'(r_acos)));
                    r_st      <= S_RS0;
                end
                S_RS0: r_st <= S_RW0;
                S_RW0: begin
                    if (cd_done) begin
                        r_st <= S_OXA;
                    end
                end
                S_OXA: r_st <= S_OXB;
                S_OXB: begin
                    r_ex <= 36'(i_root_x) + off;
                    r_st <= S_OYB;
                end
                S_OYB: begin
                    r_ey <= 36'(i_root_y) + off;
                    r_st <= S_RS1;
                end
                S_RS1: r_st <= S_RW1;
                S_RW1: begin
                    if (cd_done) begin
                        r_st <= S_OXC;
                    end
                end
                S_OXC: r_st <= S_OXD;
                S_OXD: begin
                    r_tx <= 37'(r_ex) + 37'(off);
                    r_st <= S_OYD;
                end
                S_OYD: begin
                    r_ty <= 37'(r_ey) + 37'(off);
                    r_st <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ov || o_res.ready) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_DONE && (!r_ov || o_res.ready)) begin
            r_o_sh <= r_sh_kept;
            r_o_el <= r_el_kept;
            r_o_ex <= sat24(37'(r_ex));
            r_o_ey <= sat24(37'(r_ey));
            r_o_tx <= sat24(r_tx);
            r_o_ty <= sat24(r_ty);
        end
    end

    tbpik_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cd_start),
        .i_rotate (cd_rot),
        .i_x      (cd_x),
        .i_y      (cd_y),
        .i_ang    (cd_ang),
        .o_done   (cd_done),
        .o_x      (cd_ox),
        .o_y      (cd_oy),
        .o_z      (cd_oz)
    );

endmodule

`default_nettype wire
